[src/tcpq_pkg.sv]
// shared types, constants and helpers for the three-class priority queue
package tcpq_pkg;

  localparam int unsigned CLASS_DEPTH  = 16;
  localparam int unsigned TAG_WIDTH    = 16;
  localparam int unsigned NUM_CLASSES  = 3;

  localparam int unsigned TAG_PORT_W   = 16;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned ITEM_COUNT_W = 6;

  localparam int unsigned CLS_W  = $clog2(NUM_CLASSES);
  localparam int unsigned IDX_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned CNT_W  = $clog2(NUM_CLASSES * CLASS_DEPTH + 1);
  localparam int unsigned STORE_DEPTH = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned ADDR_W = $clog2(STORE_DEPTH);

  // type characters
  localparam logic [CHAR_W-1:0] CHAR_HIGH = 8'h45;  // 'E'
  localparam logic [CHAR_W-1:0] CHAR_MID  = 8'h49;  // 'I'
  localparam logic [CHAR_W-1:0] CHAR_LOW  = 8'h44;  // 'D'

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_CLR = 2'd2,
    ACT_NOP = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_BAD_CLASS = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // store write for one step
  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [TAG_WIDTH-1:0] data;
  } store_wr_t;

  // outcome of one step and where to look up the snapshot
  typedef struct packed {
    logic                    taken_valid;
    status_e                 status;
    logic [ITEM_COUNT_W-1:0] count;
    logic                    nonempty;
    logic [ADDR_W-1:0]       front_addr;
    logic [ADDR_W-1:0]       rear_addr;
  } step_res_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [CLS_W-1:0] cls,
                                                   input logic [IDX_W-1:0] idx);
    return ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(idx);
  endfunction

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    return (pos == IDX_W'(CLASS_DEPTH - 1)) ? '0 : pos + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] pos);
    return (pos == '0) ? IDX_W'(CLASS_DEPTH - 1) : pos - IDX_W'(1);
  endfunction

endpackage

[src/tcpq_ram.sv]
// generic one-write two-read ram with registered read data
module tcpq_ram #(
  parameter int unsigned DEPTH = 48,
  parameter int unsigned WIDTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

[src/tcpq_ctrl.sv]
// per-class ring pointers, fill counts and priority selection
module tcpq_ctrl import tcpq_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [1:0]            action_i,
  input  logic [TAG_WIDTH-1:0]  tag_i,
  input  logic [CHAR_W-1:0]     class_char_i,
  output store_wr_t             wr_o,
  output step_res_t             res_o
);

  logic [IDX_W-1:0]  rd_q   [NUM_CLASSES];
  logic [IDX_W-1:0]  rd_d   [NUM_CLASSES];
  logic [IDX_W-1:0]  wr_q   [NUM_CLASSES];
  logic [IDX_W-1:0]  wr_d   [NUM_CLASSES];
  logic [FILL_W-1:0] fill_q [NUM_CLASSES];
  logic [FILL_W-1:0] fill_d [NUM_CLASSES];

  logic [CLS_W-1:0] enq_cls;
  logic             enq_cls_ok;
  logic [CLS_W-1:0] deq_cls;
  logic             deq_found;
  logic [CLS_W-1:0] front_cls;
  logic [CLS_W-1:0] rear_cls;
  logic             any_d;
  logic [CNT_W-1:0] cnt_sum;
  logic             deq_taken;
  status_e          step_status;
  action_e          act;

  assign act = action_e'(action_i);

  always_comb begin
    unique case (class_char_i)
      CHAR_HIGH: begin enq_cls = CLS_W'(0); enq_cls_ok = 1'b1; end
      CHAR_MID:  begin enq_cls = CLS_W'(1); enq_cls_ok = 1'b1; end
      CHAR_LOW:  begin enq_cls = CLS_W'(2); enq_cls_ok = 1'b1; end
      default:   begin enq_cls = '0;        enq_cls_ok = 1'b0; end
    endcase
  end

  // highest non-empty class before the step
  always_comb begin
    deq_cls   = '0;
    deq_found = 1'b0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fill_q[c] != '0) begin
        deq_cls   = CLS_W'(c);
        deq_found = 1'b1;
      end
    end
  end

  always_comb begin
    rd_d   = rd_q;
    wr_d   = wr_q;
    fill_d = fill_q;
    wr_o.en   = 1'b0;
    wr_o.addr = store_addr(enq_cls, wr_q[enq_cls]);
    wr_o.data = tag_i;
    deq_taken   = 1'b0;
    step_status = STAT_OK;
    unique case (act)
      ACT_ENQ: begin
        if (!enq_cls_ok) begin
          step_status = STAT_BAD_CLASS;
        end else if (fill_q[enq_cls] == FILL_W'(CLASS_DEPTH)) begin
          step_status = STAT_FULL;
        end else begin
          wr_o.en          = 1'b1;
          wr_d[enq_cls]    = ring_next(wr_q[enq_cls]);
          fill_d[enq_cls]  = fill_q[enq_cls] + FILL_W'(1);
        end
      end
      ACT_DEQ: begin
        if (!deq_found) begin
          step_status = STAT_EMPTY;
        end else begin
          deq_taken       = 1'b1;
          rd_d[deq_cls]   = ring_next(rd_q[deq_cls]);
          fill_d[deq_cls] = fill_q[deq_cls] - FILL_W'(1);
        end
      end
      ACT_CLR: begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
          rd_d[c]   = '0;
          wr_d[c]   = '0;
          fill_d[c] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // snapshot after the step: front from the highest class, rear from the lowest
  always_comb begin
    front_cls = '0;
    rear_cls  = '0;
    any_d     = 1'b0;
    cnt_sum   = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fill_d[c] != '0) begin
        front_cls = CLS_W'(c);
      end
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (fill_d[c] != '0) begin
        rear_cls = CLS_W'(c);
        any_d    = 1'b1;
      end
      cnt_sum = cnt_sum + CNT_W'(fill_d[c]);
    end
  end

  assign res_o = '{
    taken_valid: deq_taken,
    status:      step_status,
    count:       ITEM_COUNT_W'(cnt_sum),
    nonempty:    any_d,
    front_addr:  store_addr(front_cls, rd_d[front_cls]),
    rear_addr:   store_addr(rear_cls, ring_prev(wr_d[rear_cls]))
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        rd_q[c]   <= '0;
        wr_q[c]   <= '0;
        fill_q[c] <= '0;
      end
    end else if (step_i) begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      fill_q <= fill_d;
    end
  end

endmodule

[src/three_class_priority_queue_unit.sv]
// top level: handshake, tag store and result register of the priority queue
//
// Strict-priority queue of 16-bit tags in three classes ('E' highest, 'I', 'D' lowest),
// first in first out within a class, up to CLASS_DEPTH tags per class. One operation is
// taken per clock cycle unless a result waits with out_ready_i low: the input transfer
// updates the ring pointers and fill counts and launches the store reads for the new
// front and rear in the same cycle, and the result comes from the registered read
// data in the cycle after the transfer, so a result transfer may complete in the same
// cycle as the next input transfer. in_ready_o is low only while a result waits and
// out_ready_i is low. The tag store holds no reset state; no start-up sweep is needed.
module three_class_priority_queue_unit import tcpq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              action_i,
  input  logic [TAG_PORT_W-1:0]   item_tag_i,
  input  logic [CHAR_W-1:0]       class_char_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [TAG_PORT_W-1:0]   taken_item_o,
  output logic                    taken_valid_o,
  output logic [1:0]              status_o,
  output logic [ITEM_COUNT_W-1:0] item_count_o,
  output logic [TAG_PORT_W-1:0]   front_item_o,
  output logic [TAG_PORT_W-1:0]   rear_item_o
);

  logic      step;
  store_wr_t wr;
  step_res_t res;

  logic [TAG_WIDTH-1:0] rd_front;
  logic [TAG_WIDTH-1:0] rd_rear;
  logic [TAG_WIDTH-1:0] front_tag;
  logic [TAG_WIDTH-1:0] rear_tag;

  logic                    out_valid_q, out_valid_d;
  logic                    nonempty_q;
  logic                    taken_valid_q;
  status_e                 status_q;
  logic [ITEM_COUNT_W-1:0] count_q;
  logic [TAG_WIDTH-1:0]    taken_q;
  logic                    fwd_front_q;
  logic                    fwd_rear_q;
  logic [TAG_WIDTH-1:0]    wdata_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  tcpq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .action_i     (action_i),
    .tag_i        (TAG_WIDTH'(item_tag_i)),
    .class_char_i (class_char_i),
    .wr_o         (wr),
    .res_o        (res)
  );

  tcpq_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (TAG_WIDTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (step && wr.en),
    .waddr_i   (wr.addr),
    .wdata_i   (wr.data),
    .re_i      (step),
    .raddr_a_i (res.front_addr),
    .raddr_b_i (res.rear_addr),
    .rdata_a_o (rd_front),
    .rdata_b_o (rd_rear)
  );

  // the ram returns old data on a same-cycle write, so forward the new tag
  always_comb begin
    front_tag = '0;
    rear_tag  = '0;
    if (nonempty_q) begin
      front_tag = fwd_front_q ? wdata_q : rd_front;
      rear_tag  = fwd_rear_q  ? wdata_q : rd_rear;
    end
  end

  assign out_valid_d = step ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      nonempty_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        nonempty_q <= res.nonempty;
      end
    end
  end

  // a dequeue takes what the previous snapshot showed as the front
  always_ff @(posedge clk_i) begin
    if (step) begin
      taken_valid_q <= res.taken_valid;
      status_q      <= res.status;
      count_q       <= res.count;
      taken_q       <= res.taken_valid ? front_tag : '0;
      fwd_front_q   <= wr.en && (wr.addr == res.front_addr);
      fwd_rear_q    <= wr.en && (wr.addr == res.rear_addr);
      wdata_q       <= wr.data;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign taken_item_o  = TAG_PORT_W'(taken_q);
  assign taken_valid_o = taken_valid_q;
  assign status_o      = status_q;
  assign item_count_o  = count_q;
  assign front_item_o  = TAG_PORT_W'(front_tag);
  assign rear_item_o   = TAG_PORT_W'(rear_tag);

  a_count_matches_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((count_q == '0) == !nonempty_q))
    else $error("item count disagrees with empty flag");

  a_taken_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && taken_valid_q) |-> (status_q == STAT_OK))
    else $error("dequeued item with error status");

  a_empty_status_leaves_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == STAT_EMPTY) |-> !nonempty_q)
    else $error("empty status but queue holds items");

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("accepted operation produced no result");

endmodule

[tb/tb_three_class_priority_queue_unit.sv]
// testbench for the three-class priority queue: directed and random operations checked per transfer
module tb_three_class_priority_queue_unit import tcpq_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned RANDOM_OPS   = 450;
  localparam int unsigned SHOW_FIRST   = 10;

  typedef struct {
    logic [TAG_PORT_W-1:0]   taken;
    logic                    taken_valid;
    status_e                 status;
    logic [ITEM_COUNT_W-1:0] count;
    logic [TAG_PORT_W-1:0]   front;
    logic [TAG_PORT_W-1:0]   rear;
  } queue_snapshot_t;

  // mirror of the three class rings plus the outcomes still owed by the block
  class queue_tracker;
    logic [TAG_WIDTH-1:0] ring [NUM_CLASSES][CLASS_DEPTH];
    int unsigned          head [NUM_CLASSES];
    int unsigned          tail [NUM_CLASSES];
    int unsigned          fill [NUM_CLASSES];
    queue_snapshot_t      owed_outcomes[$];
    int unsigned          faults;
    int unsigned          results_seen;
    int unsigned          n_enq, n_taken, n_full, n_bad, n_empty, n_clear, n_idle_op;
    int unsigned          peak_count;

    function int class_of(logic [CHAR_W-1:0] ch);
      if (ch == CHAR_HIGH) return 0;
      if (ch == CHAR_MID)  return 1;
      if (ch == CHAR_LOW)  return 2;
      return -1;
    endfunction

    function queue_snapshot_t apply_operation(action_e act, logic [TAG_PORT_W-1:0] tag,
                                              logic [CHAR_W-1:0] ch);
      queue_snapshot_t s;
      int              cls;
      int unsigned     total;
      bit              found;
      s.taken       = '0;
      s.taken_valid = 1'b0;
      s.status      = STAT_OK;
      case (act)
        ACT_ENQ: begin
          cls = class_of(ch);
          if (cls < 0) begin
            s.status = STAT_BAD_CLASS;
          end else if (fill[cls] >= CLASS_DEPTH) begin
            s.status = STAT_FULL;
          end else begin
            ring[cls][tail[cls]] = tag[TAG_WIDTH-1:0];
            tail[cls] = (tail[cls] + 1) % CLASS_DEPTH;
            fill[cls]++;
          end
        end
        ACT_DEQ: begin
          s.status = STAT_EMPTY;
          found = 1'b0;
          for (int c = 0; c < NUM_CLASSES; c++) begin
            if (!found && fill[c] != 0) begin
              found = 1'b1;
              s.taken = TAG_PORT_W'(ring[c][head[c]]);
              s.taken_valid = 1'b1;
              s.status = STAT_OK;
              head[c] = (head[c] + 1) % CLASS_DEPTH;
              fill[c]--;
            end
          end
        end
        ACT_CLR: begin
          for (int c = 0; c < NUM_CLASSES; c++) begin
            head[c] = 0;
            tail[c] = 0;
            fill[c] = 0;
          end
        end
        default: ;
      endcase

      total = 0;
      for (int c = 0; c < NUM_CLASSES; c++) total += fill[c];
      s.count = ITEM_COUNT_W'(total);
      s.front = '0;
      s.rear  = '0;
      found = 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        if (!found && fill[c] != 0) begin
          found = 1'b1;
          s.front = TAG_PORT_W'(ring[c][head[c]]);
        end
      end
      found = 1'b0;
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
        if (!found && fill[c] != 0) begin
          found = 1'b1;
          s.rear = TAG_PORT_W'(ring[c][(tail[c] + CLASS_DEPTH - 1) % CLASS_DEPTH]);
        end
      end
      if (total > peak_count) peak_count = total;
      return s;
    endfunction

    function void note_input(action_e act, logic [TAG_PORT_W-1:0] tag, logic [CHAR_W-1:0] ch);
      queue_snapshot_t s;
      s = apply_operation(act, tag, ch);
      case (act)
        ACT_ENQ: begin
          if (s.status == STAT_OK) n_enq++;
          else if (s.status == STAT_FULL) n_full++;
          else n_bad++;
        end
        ACT_DEQ: begin
          if (s.taken_valid) n_taken++;
          else n_empty++;
        end
        ACT_CLR: n_clear++;
        default: n_idle_op++;
      endcase
      owed_outcomes.push_back(s);
    endfunction

    function void check_result(logic [TAG_PORT_W-1:0] taken, logic taken_valid,
                               logic [1:0] status, logic [ITEM_COUNT_W-1:0] count,
                               logic [TAG_PORT_W-1:0] front, logic [TAG_PORT_W-1:0] rear);
      queue_snapshot_t e;
      results_seen++;
      if (owed_outcomes.size() == 0) begin
        if (faults < SHOW_FIRST)
          $display("%0t: unexpected result transfer: taken=%h v=%b st=%0d cnt=%0d f=%h r=%h",
                   $realtime, taken, taken_valid, status, count, front, rear);
        faults++;
        return;
      end
      e = owed_outcomes.pop_front();
      if (taken !== e.taken || taken_valid !== e.taken_valid || status !== e.status ||
          count !== e.count || front !== e.front || rear !== e.rear) begin
        if (faults < SHOW_FIRST)
          $display("%0t: result %0d mismatch\n  exp taken=%h v=%b st=%0d cnt=%0d f=%h r=%h\n  got taken=%h v=%b st=%0d cnt=%0d f=%h r=%h",
                   $realtime, results_seen, e.taken, e.taken_valid, e.status, e.count,
                   e.front, e.rear, taken, taken_valid, status, count, front, rear);
        faults++;
      end
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic [1:0]              action_i;
  logic [TAG_PORT_W-1:0]   item_tag_i;
  logic [CHAR_W-1:0]       class_char_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [TAG_PORT_W-1:0]   taken_item_o;
  logic                    taken_valid_o;
  logic [1:0]              status_o;
  logic [ITEM_COUNT_W-1:0] item_count_o;
  logic [TAG_PORT_W-1:0]   front_item_o;
  logic [TAG_PORT_W-1:0]   rear_item_o;

  queue_tracker book;
  bit           no_idle;
  int unsigned  cycles;

  three_class_priority_queue_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .item_tag_i   (item_tag_i),
    .class_char_i (class_char_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .taken_item_o (taken_item_o),
    .taken_valid_o(taken_valid_o),
    .status_o     (status_o),
    .item_count_o (item_count_o),
    .front_item_o (front_item_o),
    .rear_item_o  (rear_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  task automatic send_op(input action_e act, input logic [TAG_PORT_W-1:0] tag,
                         input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    action_i     = act;
    item_tag_i   = tag;
    class_char_i = ch;
    do @(posedge clk_i); while (!in_ready_o);
    book.note_input(act, tag, ch);
    @(negedge clk_i);
  endtask

  // mode 0 fills, mode 1 drains, mode 2 is balanced
  task automatic send_random_op(input int unsigned mode, input int favored);
    action_e           act;
    logic [CHAR_W-1:0] ch;
    int unsigned       r;
    int unsigned       enq_pct;
    int                cls;
    enq_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
    r = $urandom_range(0, 99);
    if (r < 2) act = ACT_CLR;
    else if (r < 5) act = ACT_NOP;
    else if ($urandom_range(0, 99) < enq_pct) act = ACT_ENQ;
    else act = ACT_DEQ;
    if ($urandom_range(0, 99) < 15) begin
      ch = CHAR_W'($urandom_range(0, 255));
    end else begin
      cls = (mode == 0 && $urandom_range(0, 99) < 60) ? favored : $urandom_range(0, 2);
      ch = (cls == 0) ? CHAR_HIGH : (cls == 1) ? CHAR_MID : CHAR_LOW;
    end
    send_op(act, TAG_PORT_W'($urandom), ch);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      book.check_result(taken_item_o, taken_valid_o, status_o, item_count_o,
                        front_item_o, rear_item_o);
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      out_ready_i = 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      stall = no_idle ? 0 : pick_gap();
      if (stall > 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycles, book.owed_outcomes.size());
    $display("tb_three_class_priority_queue_unit: done, errors");
    $finish;
  end

  initial begin
    int unsigned mode;
    int          favored;
    book         = new;
    no_idle      = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    action_i     = ACT_NOP;
    item_tag_i   = '0;
    class_char_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty take, unused code, invalid classes, each class, clear, full class
    send_op(ACT_DEQ, 16'h0000, CHAR_HIGH);
    send_op(ACT_NOP, 16'hFFFF, 8'hFF);
    send_op(ACT_ENQ, 16'h1111, 8'h00);
    send_op(ACT_ENQ, 16'h2222, 8'hFF);
    send_op(ACT_ENQ, 16'hFFFF, CHAR_HIGH);
    send_op(ACT_ENQ, 16'h0000, CHAR_MID);
    send_op(ACT_ENQ, 16'h8001, CHAR_LOW);
    send_op(ACT_DEQ, 16'h0000, 8'h00);
    send_op(ACT_CLR, 16'h0000, 8'h00);
    send_op(ACT_DEQ, 16'h0000, 8'h00);
    for (int i = 0; i <= CLASS_DEPTH; i++)
      send_op(ACT_ENQ, TAG_PORT_W'(16'hD000 + i), CHAR_LOW);

    mode = 0;
    favored = 0;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 50 == 0) begin
        mode    = $urandom_range(0, 2);
        favored = $urandom_range(0, 2);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      send_random_op(mode, favored);
    end
    in_valid_i = 1'b0;
    no_idle    = 1'b0;

    while (book.owed_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (book.owed_outcomes.size() != 0) begin
      $display("%0d results never arrived", book.owed_outcomes.size());
      book.faults++;
    end

    $display("covered %0d enqueues, %0d takes, %0d empty takes, %0d full drops, %0d bad class",
             book.n_enq, book.n_taken, book.n_empty, book.n_full, book.n_bad);
    $display("  %0d clears, %0d unused codes, peak fill %0d, %0d results, %0d faults",
             book.n_clear, book.n_idle_op, book.peak_count, book.results_seen, book.faults);
    if (book.faults == 0)
      $display("tb_three_class_priority_queue_unit: done, clean");
    else
      $display("tb_three_class_priority_queue_unit: done, errors");
    $finish;
  end

endmodule
